@@ hdl/cnfsa_pkg.sv @@
`timescale 1ns / 1ps

package cnfsa_pkg;

   localparam int DEF_SLOTS = 256;
   localparam int WORD_W    = 32;
   localparam int WBIT_W    = 5;
   localparam int PLACES_W  = 9;
   localparam int SLOT_W    = 8;
   localparam int STATUS_W  = 3;

   localparam logic [PLACES_W-1:0] PLACES_RESET = 9'd256;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_GRANTED      = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_RELEASED     = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL         = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_NOT_OCCUPIED = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_INVALID      = 3'd4;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_SCAN,
      S_RESP
   } state_type;

endpackage

@@ hdl/circular_next_free_slot_allocator_unit.sv @@
`timescale 1ns / 1ps

// Circular first-fit slot allocator. Keeps one occupancy bit per slot in a
// word-wide memory (32 slots per word, one valid bit per word so the whole map
// reads as free right after reset, no clearing pass). An allocate beat names a
// preferred slot: it is granted if free, otherwise the lowest free slot above
// it, otherwise the lowest free slot below it; status full if none. A release
// beat frees an occupied slot or reports it was not occupied. Slots at or
// beyond min(places_in_use, SLOTS) report invalid and change nothing.
// The block takes one request at a time. A request is accepted in the idle
// state; each occupancy word visited then takes a memory read state and a
// scan/update state; the result state then moves the result to the output
// register, waiting while rsp_stall holds it. Release and any out-of-range
// slot visit at most one word. Allocate walks the words circularly from the
// preferred slot's word, worst case ceil(n/32)+1 words; the memory's single
// read port and the one 32-bit scan unit make it go word by word. req_stall
// is high from acceptance until the result moves into the output register.
// csr_ready is always high; write places_in_use only while the block is idle.

module circular_next_free_slot_allocator_unit
   import cnfsa_pkg::*;
#(
   parameter int SLOTS = DEF_SLOTS
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_op,
   input  logic [SLOT_W-1:0]   req_slot,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SLOT_W-1:0]   rsp_granted_slot,

   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [PLACES_W-1:0] csr_data
);

   // Geometry
   localparam int WORDS  = (SLOTS + WORD_W - 1) / WORD_W;
   localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int G_W    = WIDX_W + WBIT_W;
   localparam int CW0    = (G_W > CNT_W) ? G_W : CNT_W;
   localparam int CW1    = (CW0 > PLACES_W) ? CW0 : PLACES_W;
   localparam int CW     = (CW1 > SLOT_W) ? CW1 : SLOT_W;

   // Control / request registers
   state_type              state_ff, state_in;
   logic                   op_ff, op_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [CNT_W-1:0]       n_ff, n_in;
   logic [WIDX_W-1:0]      start_ff, start_in;
   logic [WIDX_W-1:0]      last_ff, last_in;
   logic [WIDX_W-1:0]      wi_ff, wi_in;
   logic                   wrap_ff, wrap_in;
   logic [STATUS_W-1:0]    res_status_ff, res_status_in;
   logic [SLOT_W-1:0]      res_slot_ff, res_slot_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]      rsp_slot_ff, rsp_slot_in;

   logic [PLACES_W-1:0]    places_ff, places_in;

   // Occupancy store
   logic [WORD_W-1:0]      mem [WORDS];
   logic [WORDS-1:0]       row_valid_ff, row_valid_in;
   logic [WORD_W-1:0]      rd_data_ff;
   logic                   rd_valid_ff;
   logic                   wr_en;
   logic [WORD_W-1:0]      wr_data;

   // Scan datapath
   logic [CW-1:0]          places_ext, slots_ext, n_cur_ext, n_ext, slot_ext;
   logic [CW-1:0]          g_ext;
   logic [CW-1:0]          last_cur_ext;
   logic [WORD_W-1:0]      word;
   logic [WORD_W-1:0]      allow;
   logic [WORD_W-1:0]      free_bits;
   logic [WBIT_W-1:0]      pick_b;
   logic                   rsp_load;

   assign csr_ready = 1'b1;

   // Effective slot count for the incoming beat
   assign places_ext   = CW'(places_ff);
   assign slots_ext    = CW'(SLOTS);
   assign n_cur_ext    = (places_ext > slots_ext) ? slots_ext : places_ext;
   assign last_cur_ext = (n_cur_ext - CW'(1)) >> WBIT_W;

   assign n_ext    = CW'(n_ff);
   assign slot_ext = CW'(slot_ff);
   assign word     = rd_valid_ff ? rd_data_ff : '0;

   // Per-bit window: inside [slot, n) on the first lap, [0, slot) after wrap
   always_comb begin
      g_ext = '0;
      allow = '0;
      for (int b = 0; b < WORD_W; b++) begin
         g_ext    = CW'({wi_ff, WBIT_W'(b)});
         allow[b] = (g_ext < n_ext) && (wrap_ff ? (g_ext < slot_ext) : (g_ext >= slot_ext));
      end
   end

   assign free_bits = ~word & allow;

   // Lowest free bit
   always_comb begin
      pick_b = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (free_bits[b]) begin
            pick_b = WBIT_W'(b);
         end
      end
   end

   assign rsp_load = !rsp_valid_ff || !rsp_stall;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      slot_in       = slot_ff;
      n_in          = n_ff;
      start_in      = start_ff;
      last_in       = last_ff;
      wi_in         = wi_ff;
      wrap_in       = wrap_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      row_valid_in  = row_valid_ff;
      wr_en         = 1'b0;
      wr_data       = word;
      places_in     = (csr_valid && csr_ready) ? csr_data : places_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_op;
               slot_in  = req_slot;
               n_in     = CNT_W'(n_cur_ext);
               start_in = WIDX_W'(req_slot[SLOT_W-1:WBIT_W]);
               last_in  = WIDX_W'(last_cur_ext);
               wi_in    = WIDX_W'(req_slot[SLOT_W-1:WBIT_W]);
               wrap_in  = 1'b0;
               if (CW'(req_slot) >= n_cur_ext) begin
                  res_status_in = STAT_INVALID;
                  res_slot_in   = '0;
                  state_in      = S_RESP;
               end else begin
                  state_in = S_READ;
               end
            end
         end

         S_READ: begin
            state_in = S_SCAN;
         end

         S_SCAN: begin
            res_slot_in = '0;
            if (op_ff == OP_RELEASE) begin
               if (word[slot_ff[WBIT_W-1:0]]) begin
                  wr_en         = 1'b1;
                  wr_data       = word & ~(WORD_W'(1) << slot_ff[WBIT_W-1:0]);
                  res_status_in = STAT_RELEASED;
               end else begin
                  res_status_in = STAT_NOT_OCCUPIED;
               end
               state_in = S_RESP;
            end else if (|free_bits) begin
               wr_en         = 1'b1;
               wr_data       = word | (WORD_W'(1) << pick_b);
               res_status_in = STAT_GRANTED;
               res_slot_in   = SLOT_W'({wi_ff, pick_b});
               state_in      = S_RESP;
            end else if (wrap_ff && (wi_ff == start_ff)) begin
               res_status_in = STAT_FULL;
               state_in      = S_RESP;
            end else if (wi_ff == last_ff) begin
               wi_in    = '0;
               wrap_in  = 1'b1;
               state_in = S_READ;
            end else begin
               wi_in    = wi_ff + WIDX_W'(1);
               state_in = S_READ;
            end
            if (wr_en) begin
               row_valid_in[wi_ff] = 1'b1;
            end
         end

         S_RESP: begin
            if (rsp_load) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         places_ff    <= PLACES_RESET;
         row_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         places_ff    <= places_in;
         row_valid_ff <= row_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      slot_ff       <= slot_in;
      n_ff          <= n_in;
      start_ff      <= start_in;
      last_ff       <= last_in;
      wi_ff         <= wi_in;
      wrap_ff       <= wrap_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   // Occupancy memory: one read and one write port, same address
   always_ff @(posedge clock) begin
      rd_data_ff  <= mem[wi_ff];
      rd_valid_ff <= row_valid_ff[wi_ff];
      if (wr_en) begin
         mem[wi_ff] <= wr_data;
      end
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_granted_slot = rsp_slot_ff;

   // Checks
   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted but block not busy next cycle");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESP))
      else $error("result appeared outside the result state");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> (wi_ff <= last_ff))
      else $error("word index beyond last active word");

   a_nongrant_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != STAT_GRANTED)) |-> (rsp_slot_ff == '0))
      else $error("non-grant result carries a slot index");

endmodule
